[design/esol_pkg.sv]
// shared types, constants and the quarter-wave sine table for the enveloped lowpass
package esol_pkg;

  // channel count and sine table size
  localparam int CHANNELS         = 2;
  localparam int SINE_TABLE_DEPTH = 256;
  localparam int CH_W             = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int IDX_W            = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int SINE_IDX_SHIFT   = 14 - $clog2(SINE_TABLE_DEPTH);

  // fixed-point constants
  localparam logic [16:0] LEVEL_ONE   = 17'd65536;
  localparam logic [15:0] COEF_MIN    = 16'd1;
  localparam logic [15:0] COEF_MAX    = 16'd65535;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // register reset values
  localparam logic [15:0] CUTOFF_RATIO_RST  = 16'd32768;
  localparam logic [15:0] DECAY_FACTOR_RST  = 16'd65470;
  localparam logic [15:0] ATTACK_FACTOR_RST = 16'd60000;
  localparam logic [15:0] DROP_LEVEL_RST    = 16'd66;
  localparam logic [15:0] OUTPUT_GAIN_RST   = 16'd256;

  // register indexes
  localparam logic [2:0] CFG_CUTOFF_RATIO  = 3'd0;
  localparam logic [2:0] CFG_DECAY_FACTOR  = 3'd1;
  localparam logic [2:0] CFG_ATTACK_FACTOR = 3'd2;
  localparam logic [2:0] CFG_DROP_LEVEL    = 3'd3;
  localparam logic [2:0] CFG_OUTPUT_GAIN   = 3'd4;

  typedef enum logic [1:0] {
    CMD_SAMPLE  = 2'd0,
    CMD_TRIGGER = 2'd1,
    CMD_BYPASS  = 2'd2,
    CMD_STOP    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_RUN    = 2'd1,
    MODE_BYPASS = 2'd2
  } env_mode_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CMD,
    OP_AMP,
    OP_DEC,
    OP_ATT,
    OP_CUT,
    OP_COEF,
    OP_FILT,
    OP_OUT1,
    OP_OUT2
  } dp_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AMP,
    ST_DEC,
    ST_ATT,
    ST_CUT,
    ST_COEF,
    ST_FILT,
    ST_OUT1,
    ST_OUT2
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_sample;
  } dp_status_t;

  typedef logic [16:0] sine_tbl_t [SINE_TABLE_DEPTH + 1];

  // one table entry: taylor series of sin in q2.30, rounded to q1.16
  function automatic logic [16:0] sine_entry(int unsigned k);
    logic [63:0] x;
    logic [63:0] t;
    logic [63:0] rnd;
    longint      acc;
    x   = HALF_PI_Q30 * 64'(k) / 64'(SINE_TABLE_DEPTH);
    t   = x;
    acc = longint'(x);
    for (int n = 1; n <= 6; n++) begin
      t = (t * x) >> 30;
      t = (t * x) >> 30;
      case (n)
        1:       t = t / 64'd6;
        2:       t = t / 64'd20;
        3:       t = t / 64'd42;
        4:       t = t / 64'd72;
        5:       t = t / 64'd110;
        default: t = t / 64'd156;
      endcase
      if ((n & 1) == 1) acc = acc - longint'(t);
      else acc = acc + longint'(t);
    end
    if (acc < 0) acc = 0;
    rnd = (64'(acc) + 64'd8192) >> 14;
    return (rnd > 64'(LEVEL_ONE)) ? LEVEL_ONE : rnd[16:0];
  endfunction

  function automatic sine_tbl_t sine_table();
    sine_tbl_t tbl;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      tbl[k] = sine_entry(k);
    end
    return tbl;
  endfunction

  localparam sine_tbl_t SINE_TBL = sine_table();

endpackage

[design/esol_ctrl.sv]
// step sequencer for one word: envelope, cutoff, coefficient, filter and output scaling
module esol_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  esol_pkg::dp_status_t status_i,
  output esol_pkg::dp_cmd_t   ctrl_o
);
  import esol_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  // state and output valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and datapath step
  always_comb begin
    state_d     = state_q;
    ctrl_o.op   = OP_NONE;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (status_i.is_sample) begin
            ctrl_o.op = OP_LOAD;
            state_d   = ST_AMP;
          end else begin
            ctrl_o.op = OP_CMD;
          end
        end
      end
      ST_AMP: begin
        ctrl_o.op = OP_AMP;
        state_d   = ST_DEC;
      end
      ST_DEC: begin
        ctrl_o.op = OP_DEC;
        state_d   = ST_ATT;
      end
      ST_ATT: begin
        ctrl_o.op = OP_ATT;
        state_d   = ST_CUT;
      end
      ST_CUT: begin
        ctrl_o.op = OP_CUT;
        state_d   = ST_COEF;
      end
      ST_COEF: begin
        ctrl_o.op = OP_COEF;
        state_d   = ST_FILT;
      end
      ST_FILT: begin
        ctrl_o.op = OP_FILT;
        state_d   = ST_OUT1;
      end
      ST_OUT1: begin
        ctrl_o.op = OP_OUT1;
        state_d   = ST_OUT2;
      end
      ST_OUT2: begin
        // wait until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          ctrl_o.op   = OP_OUT2;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_valid_from_last_step: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_OUT2
  ) else $error("output valid raised outside the last step");

  a_hold_while_full: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT2 && out_valid_q && out_stall_i) |=> (state_q == ST_OUT2 && out_valid_q)
  ) else $error("result step left while output register was full");

  a_sample_starts: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && in_valid_i && status_i.is_sample) |=> state_q == ST_AMP
  ) else $error("accepted sample did not start the envelope step");
`endif

endmodule

[design/esol_dpath.sv]
// envelope, coefficient and filter datapath around one shared multiplier
module esol_dpath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [15:0]          cfg_wdata_i,
  input  logic [1:0]           cmd_i,
  input  logic                 channel_i,
  input  logic signed [15:0]   sample_in_i,
  input  esol_pkg::dp_cmd_t    ctrl_i,
  output esol_pkg::dp_status_t status_o,
  output logic signed [15:0]   sample_out_o,
  output logic [1:0]           env_status_o
);
  import esol_pkg::*;

  // configuration registers
  logic [15:0] cutoff_q, cutoff_d;
  logic [15:0] decay_factor_q, decay_factor_d;
  logic [15:0] attack_factor_q, attack_factor_d;
  logic [15:0] drop_q, drop_d;
  logic [15:0] gain_q, gain_d;

  // envelope and filter state
  env_mode_e          mode_q, mode_d;
  logic [16:0]        dec_q, dec_d;
  logic [16:0]        att_q, att_d;
  logic signed [23:0] fmem_q [CHANNELS];
  logic signed [23:0] fmem_d [CHANNELS];

  // per-word working registers
  logic [CH_W-1:0]    ch_q, ch_d;
  logic signed [15:0] x_q, x_d;
  logic [16:0]        amp_q, amp_d;
  logic [15:0]        r_q, r_d;
  logic [15:0]        coef_q, coef_d;
  logic signed [40:0] prod_q, prod_d;
  logic signed [15:0] out_q, out_d;
  env_mode_e          env_q, env_d;

  // shared multiplier
  logic signed [41:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [59:0] mul_p;

  logic signed [23:0] y_cur;
  logic signed [23:0] x_sh;
  logic signed [24:0] diff;
  logic signed [23:0] y_new;
  logic [15:0]        fold16;
  logic [14:0]        fold;
  logic [14:0]        fold_sh;
  logic [IDX_W-1:0]   sidx;
  logic [16:0]        sval;
  logic [15:0]        coef_val;
  logic signed [27:0] scaled;
  logic signed [15:0] sat_val;

  assign status_o.is_sample = (cmd_e'(cmd_i) == CMD_SAMPLE);

  assign y_cur = fmem_q[ch_q];
  assign x_sh  = {x_q, 8'd0};
  assign diff  = {x_sh[23], x_sh} - {y_cur[23], y_cur};

  // operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl_i.op)
      OP_AMP: begin
        mul_a = {25'd0, LEVEL_ONE - att_q};
        mul_b = {1'b0, dec_q};
      end
      OP_DEC: begin
        mul_a = {25'd0, dec_q};
        mul_b = {2'b00, decay_factor_q};
      end
      OP_ATT: begin
        mul_a = {25'd0, att_q};
        mul_b = {2'b00, attack_factor_q};
      end
      OP_CUT: begin
        mul_a = {26'd0, cutoff_q};
        mul_b = {1'b0, amp_q};
      end
      OP_FILT: begin
        mul_a = {{17{diff[24]}}, diff};
        mul_b = {2'b00, coef_q};
      end
      OP_OUT1: begin
        mul_a = {{18{y_cur[23]}}, y_cur};
        mul_b = {1'b0, amp_q};
      end
      OP_OUT2: begin
        mul_a = {prod_q[40], prod_q};
        mul_b = {2'b00, gain_q};
      end
      default: begin
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // coefficient from the folded quarter-wave table
  assign fold16  = 16'd32768 - r_q;
  assign fold    = r_q[14] ? fold16[14:0] : r_q[14:0];
  assign fold_sh = fold >> SINE_IDX_SHIFT;
  assign sidx    = fold_sh[IDX_W-1:0];
  assign sval    = SINE_TBL[sidx];

  always_comb begin
    if (r_q[15] || sval == 17'd0) coef_val = COEF_MIN;
    else if (sval[16]) coef_val = COEF_MAX;
    else coef_val = sval[15:0];
  end

  // filter update, wraps to 24 bits
  assign y_new = y_cur + mul_p[39:16];

  // output scaling with saturation
  assign scaled = mul_p[59:32];
  always_comb begin
    if (scaled > 28'sd32767) sat_val = 16'sh7fff;
    else if (scaled < -28'sd32768) sat_val = 16'sh8000;
    else sat_val = scaled[15:0];
  end

  // next values
  always_comb begin
    cutoff_d        = cutoff_q;
    decay_factor_d  = decay_factor_q;
    attack_factor_d = attack_factor_q;
    drop_d          = drop_q;
    gain_d          = gain_q;
    mode_d          = mode_q;
    dec_d           = dec_q;
    att_d           = att_q;
    fmem_d          = fmem_q;
    ch_d            = ch_q;
    x_d             = x_q;
    amp_d           = amp_q;
    r_d             = r_q;
    coef_d          = coef_q;
    prod_d          = prod_q;
    out_d           = out_q;
    env_d           = env_q;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CUTOFF_RATIO:  cutoff_d        = cfg_wdata_i;
        CFG_DECAY_FACTOR:  decay_factor_d  = cfg_wdata_i;
        CFG_ATTACK_FACTOR: attack_factor_d = cfg_wdata_i;
        CFG_DROP_LEVEL:    drop_d          = cfg_wdata_i;
        CFG_OUTPUT_GAIN:   gain_d          = cfg_wdata_i;
        default: begin
        end
      endcase
    end

    case (ctrl_i.op)
      OP_CMD: begin
        dec_d = LEVEL_ONE;
        att_d = LEVEL_ONE;
        case (cmd_e'(cmd_i))
          CMD_TRIGGER: mode_d = MODE_RUN;
          CMD_BYPASS:  mode_d = MODE_BYPASS;
          default:     mode_d = MODE_IDLE;
        endcase
      end
      OP_LOAD: begin
        ch_d = (CHANNELS > 1) ? CH_W'(channel_i) : '0;
        x_d  = sample_in_i;
        // note end
        if (mode_q == MODE_RUN && dec_q < {1'b0, drop_q}) mode_d = MODE_IDLE;
      end
      OP_AMP: begin
        if (mode_q == MODE_RUN) amp_d = mul_p[32:16];
        else if (mode_q == MODE_BYPASS) amp_d = LEVEL_ONE;
        else amp_d = '0;
      end
      OP_DEC: begin
        dec_d = (mode_q == MODE_RUN) ? mul_p[32:16] : LEVEL_ONE;
      end
      OP_ATT: begin
        att_d = (mode_q == MODE_RUN) ? mul_p[32:16] : LEVEL_ONE;
      end
      OP_CUT: begin
        r_d = mul_p[31:16];
      end
      OP_COEF: begin
        coef_d = coef_val;
      end
      OP_FILT: begin
        fmem_d[ch_q] = y_new;
      end
      OP_OUT1: begin
        prod_d = mul_p[40:0];
      end
      OP_OUT2: begin
        out_d = sat_val;
        env_d = mode_q;
      end
      default: begin
      end
    endcase
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q        <= CUTOFF_RATIO_RST;
      decay_factor_q  <= DECAY_FACTOR_RST;
      attack_factor_q <= ATTACK_FACTOR_RST;
      drop_q          <= DROP_LEVEL_RST;
      gain_q          <= OUTPUT_GAIN_RST;
      mode_q          <= MODE_IDLE;
      dec_q           <= LEVEL_ONE;
      att_q           <= LEVEL_ONE;
      for (int i = 0; i < CHANNELS; i++) begin
        fmem_q[i] <= '0;
      end
    end else begin
      cutoff_q        <= cutoff_d;
      decay_factor_q  <= decay_factor_d;
      attack_factor_q <= attack_factor_d;
      drop_q          <= drop_d;
      gain_q          <= gain_d;
      mode_q          <= mode_d;
      dec_q           <= dec_d;
      att_q           <= att_d;
      fmem_q          <= fmem_d;
    end
  end

  // working and output registers
  always_ff @(posedge clk_i) begin
    ch_q   <= ch_d;
    x_q    <= x_d;
    amp_q  <= amp_d;
    r_q    <= r_d;
    coef_q <= coef_d;
    prod_q <= prod_d;
    out_q  <= out_d;
    env_q  <= env_d;
  end

  assign sample_out_o = out_q;
  assign env_status_o = env_q;

endmodule

[design/envelope_swept_onepole_lowpass.sv]
// top level of the enveloped, swept one-pole lowpass
//
// Input words carry a command, a channel and a Q1.15 sample. Trigger, bypass
// and stop commands give no result. A sample word gives one
// result word: the filtered, enveloped Q1.15 sample and the envelope mode.
// Both channels use valid and stall; a word moves when valid is high and stall
// is low. Registers are written through cfg_we_i / cfg_idx_i / cfg_wdata_i;
// the user must write them only while the block is idle, which it does not enforce.
// A taken sample runs through eight steps after the accept: amp, dec, att,
// cut, coef, filt, out1 and out2, using the one shared multiplier and the sine
// table; the result is registered in the last step, and no new word is taken until then.
// The output register lets a finished word wait while the block goes on;
// when the receiver stalls with a word still waiting, the next result holds in
// its last step and input stall stays high.
// Reset: mode idle, both levels one, filter memories zero, registers at their
// default values, no result pending.
module envelope_swept_onepole_lowpass (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          cmd_i,
  input  logic                channel_i,
  input  logic signed [15:0]  sample_in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [15:0]  sample_out_o,
  output logic [1:0]          env_status_o
);
  import esol_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  // sequencer
  esol_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (dp_status),
    .ctrl_o      (dp_cmd)
  );

  // arithmetic and state
  esol_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .cmd_i        (cmd_i),
    .channel_i    (channel_i),
    .sample_in_i  (sample_in_i),
    .ctrl_i       (dp_cmd),
    .status_o     (dp_status),
    .sample_out_o (sample_out_o),
    .env_status_o (env_status_o)
  );

endmodule
